// File: rtl/core/triangle_corner_angles_unit_defines.svh
// Assertion macros for the triangle corner angle block.
`ifndef TRIANGLE_CORNER_ANGLES_UNIT_DEFINES_SVH
`define TRIANGLE_CORNER_ANGLES_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TCA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TCA_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) cond |=> prop) else $error(msg);
`else
`define TCA_ASSERT(name, prop, msg)
`define TCA_ASSERT_NEXT(name, cond, prop, msg)
`endif
`endif

// File: rtl/core/tca_pkg.sv
package tca_pkg;
  localparam int COORD_WIDTH     = 16;
  localparam int DIFF_W          = COORD_WIDTH + 1;
  localparam int PROD_W          = 2 * DIFF_W;
  localparam int SUM_W           = PROD_W + 2;
  localparam int MAG_W           = SUM_W - 1;
  localparam int NORM_W          = 30;
  localparam int SQ_W            = 2 * NORM_W;
  localparam int S2_W            = SQ_W + 2;
  localparam int ROOT_W          = S2_W / 2;
  localparam int REM_W           = 64;
  localparam int KSH_W           = 3;
  localparam int CORDIC_STEPS    = 27;
  localparam int CW              = 36;
  localparam int ZW              = 30;
  localparam int TAB_W           = 26;
  localparam int INNER_FRAC      = 20;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ANGLE_W         = 16;
  localparam int T_W             = 29;
  localparam int RND_SH          = INNER_FRAC - ANGLE_FRAC_BITS;
  localparam int ISQRT_LAT       = ROOT_W;
  localparam int CORDIC_LAT      = CORDIC_STEPS;
  localparam int LANE_LAT        = 6 + ISQRT_LAT + CORDIC_LAT + 1;

  localparam logic [T_W-1:0] DEG90  = T_W'(90)  << INNER_FRAC;
  localparam logic [T_W-1:0] DEG180 = T_W'(180) << INNER_FRAC;

  localparam logic [TAB_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
    26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121, 26'd3750058,
    26'd1876857, 26'd938658, 26'd469357, 26'd234682, 26'd117342,
    26'd58671, 26'd29335, 26'd14668, 26'd7334, 26'd3667, 26'd1833,
    26'd917, 26'd458, 26'd229, 26'd115, 26'd57, 26'd29, 26'd14,
    26'd7, 26'd4, 26'd2, 26'd1
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } point_t;
endpackage

// File: rtl/core/tca_isqrt.sv
module tca_isqrt
  import tca_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [S2_W-1:0]   radicand,
  output logic [ROOT_W-1:0] root
);
  logic [REM_W-1:0]  rem [ISQRT_LAT+1];
  logic [ROOT_W-1:0] res [ISQRT_LAT+1];

  assign rem[0] = REM_W'(radicand);
  assign res[0] = '0;

  for (genvar s = 0; s < ISQRT_LAT; s++) begin : g_step
    localparam int B = ROOT_W - 1 - s;
    logic [REM_W-1:0] trial;
    assign trial = (REM_W'(res[s]) << (B + 1)) | (REM_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[s] >= trial) begin
          rem[s+1] <= rem[s] - trial;
          res[s+1] <= res[s] | (ROOT_W'(1) << B);
        end else begin
          rem[s+1] <= rem[s];
          res[s+1] <= res[s];
        end
      end
    end
  end

  assign root = res[ISQRT_LAT];
endmodule

// File: rtl/core/tca_cordic.sv
module tca_cordic
  import tca_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic signed [ZW-1:0] z_out
);
  logic signed [CW-1:0] xs [CORDIC_LAT+1];
  logic signed [CW-1:0] ys [CORDIC_LAT+1];
  logic signed [ZW-1:0] zs [CORDIC_LAT+1];

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = '0;

  for (genvar i = 0; i < CORDIC_LAT; i++) begin : g_step
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] da;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign da = ZW'(ATAN_TABLE[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[i][CW-1]) begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + da;
        end else begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - da;
        end
      end
    end
  end

  assign z_out = zs[CORDIC_LAT];
endmodule

// File: rtl/core/tca_lane.sv
module tca_lane
  import tca_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  point_t             pa,
  input  point_t             pb,
  input  point_t             pc,
  output logic [ANGLE_W-1:0] angle
);
  logic signed [DIFF_W-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [PROD_W-1:0] p [9];
  logic signed [SUM_W-1:0]  crx, cry, crz, dot;
  logic [MAG_W-1:0]         mx, my, mz, md, mall;
  logic [KSH_W-1:0]         ksh;
  logic [NORM_W-1:0]        nx, ny, nz, nd;
  logic                     dneg4, dneg5, dneg6;
  logic [SQ_W-1:0]          sqx, sqy, sqz;
  logic [NORM_W-1:0]        nd5, nd6;
  logic [S2_W-1:0]          s2;
  logic [ROOT_W-1:0]        root;
  logic [NORM_W-1:0]        nd_q [ISQRT_LAT+1];
  logic                     dn_q [ISQRT_LAT+1];
  logic                     zr_q [CORDIC_LAT+1];
  logic                     dn2_q [CORDIC_LAT+1];
  logic signed [ZW-1:0]     z;
  logic [T_W-1:0]           tcl, tfin;

  always_ff @(posedge clk) begin
    if (en) begin
      ux <= DIFF_W'(pa.x) - DIFF_W'(pc.x);
      uy <= DIFF_W'(pa.y) - DIFF_W'(pc.y);
      uz <= DIFF_W'(pa.z) - DIFF_W'(pc.z);
      vx <= DIFF_W'(pb.x) - DIFF_W'(pc.x);
      vy <= DIFF_W'(pb.y) - DIFF_W'(pc.y);
      vz <= DIFF_W'(pb.z) - DIFF_W'(pc.z);
      p[0] <= uy * vz;
      p[1] <= uz * vy;
      p[2] <= uz * vx;
      p[3] <= ux * vz;
      p[4] <= ux * vy;
      p[5] <= uy * vx;
      p[6] <= ux * vx;
      p[7] <= uy * vy;
      p[8] <= uz * vz;
      crx <= SUM_W'(p[0]) - SUM_W'(p[1]);
      cry <= SUM_W'(p[2]) - SUM_W'(p[3]);
      crz <= SUM_W'(p[4]) - SUM_W'(p[5]);
      dot <= SUM_W'(p[6]) + SUM_W'(p[7]) + SUM_W'(p[8]);
    end
  end

  always_comb begin
    mx = crx[SUM_W-1] ? MAG_W'(-crx) : MAG_W'(crx);
    my = cry[SUM_W-1] ? MAG_W'(-cry) : MAG_W'(cry);
    mz = crz[SUM_W-1] ? MAG_W'(-crz) : MAG_W'(crz);
    md = dot[SUM_W-1] ? MAG_W'(-dot) : MAG_W'(dot);
    mall = mx | my | mz | md;
    ksh = '0;
    for (int j = NORM_W; j < MAG_W; j++) begin
      if (mall[j]) ksh = KSH_W'(j - NORM_W + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx <= NORM_W'(mx >> ksh);
      ny <= NORM_W'(my >> ksh);
      nz <= NORM_W'(mz >> ksh);
      nd <= NORM_W'(md >> ksh);
      dneg4 <= dot[SUM_W-1];
      sqx <= nx * nx;
      sqy <= ny * ny;
      sqz <= nz * nz;
      nd5 <= nd;
      dneg5 <= dneg4;
      s2 <= S2_W'(sqx) + S2_W'(sqy) + S2_W'(sqz);
      nd6 <= nd5;
      dneg6 <= dneg5;
    end
  end

  tca_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s2),
    .root     (root)
  );

  assign nd_q[0] = nd6;
  assign dn_q[0] = dneg6;
  for (genvar s = 0; s < ISQRT_LAT; s++) begin : g_sq_side
    always_ff @(posedge clk) begin
      if (en) begin
        nd_q[s+1] <= nd_q[s];
        dn_q[s+1] <= dn_q[s];
      end
    end
  end

  tca_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .x_in  (CW'(nd_q[ISQRT_LAT])),
    .y_in  (CW'(root)),
    .z_out (z)
  );

  assign zr_q[0]  = (root == '0);
  assign dn2_q[0] = dn_q[ISQRT_LAT];
  for (genvar s = 0; s < CORDIC_LAT; s++) begin : g_co_side
    always_ff @(posedge clk) begin
      if (en) begin
        zr_q[s+1]  <= zr_q[s];
        dn2_q[s+1] <= dn2_q[s];
      end
    end
  end

  always_comb begin
    if (zr_q[CORDIC_LAT] || z[ZW-1]) begin
      tcl = '0;
    end else if (T_W'(z) > DEG90) begin
      tcl = DEG90;
    end else begin
      tcl = T_W'(z);
    end
    tfin = dn2_q[CORDIC_LAT] ? DEG180 - tcl : tcl;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= ANGLE_W'((tfin + (T_W'(1) << (RND_SH - 1))) >> RND_SH);
    end
  end
endmodule

// File: rtl/core/triangle_corner_angles_unit.sv
// Triangle corner angles from the vertex difference vectors, evaluated as atan2(|u x v|, u.v).
// Input channel: nine signed 16-bit coordinates p1_*, p2_*, p3_* with in_valid;
// an item transfers when in_valid is high and in_stall is low.
// Output channel: angle_opp_a/b/c in degrees with 8 fraction bits and the
// degenerate flag, with out_valid; a result transfers when out_stall is low.
// Three identical corner lanes run side by side, each a 65-stage pipeline
// (products, normalize, squares, 31-stage square root, 27-stage CORDIC,
// rounding); a merge register joins them with the degenerate flag.
// Throughput: one triangle per cycle while the output is not stalled.
// When any two vertices coincide, degenerate is 1 and all angles are 0.
// When the output is valid and stalled, the whole pipeline holds and in_stall
// rises in the same cycle; it drops as soon as the result transfers.
// Reset (rst, synchronous) clears all valid bits; no result is pending after it.
module triangle_corner_angles_unit
  import tca_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] p1_x,
  input  logic signed [COORD_WIDTH-1:0] p1_y,
  input  logic signed [COORD_WIDTH-1:0] p1_z,
  input  logic signed [COORD_WIDTH-1:0] p2_x,
  input  logic signed [COORD_WIDTH-1:0] p2_y,
  input  logic signed [COORD_WIDTH-1:0] p2_z,
  input  logic signed [COORD_WIDTH-1:0] p3_x,
  input  logic signed [COORD_WIDTH-1:0] p3_y,
  input  logic signed [COORD_WIDTH-1:0] p3_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ANGLE_W-1:0]            angle_opp_a,
  output logic [ANGLE_W-1:0]            angle_opp_b,
  output logic [ANGLE_W-1:0]            angle_opp_c,
  output logic                          degenerate
);
`include "triangle_corner_angles_unit_defines.svh"

  point_t              pt1, pt2, pt3;
  logic                en;
  logic                vld_pipe [LANE_LAT];
  logic                deg_pipe [LANE_LAT];
  logic                deg_in;
  logic [ANGLE_W-1:0]  ang_a, ang_b, ang_c;

  assign pt1 = '{x: p1_x, y: p1_y, z: p1_z};
  assign pt2 = '{x: p2_x, y: p2_y, z: p2_z};
  assign pt3 = '{x: p3_x, y: p3_y, z: p3_z};

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign deg_in   = (pt1 == pt2) || (pt2 == pt3) || (pt3 == pt1);

  tca_lane u_lane_a (.clk(clk), .en(en), .pa(pt1), .pb(pt2), .pc(pt3), .angle(ang_a));
  tca_lane u_lane_b (.clk(clk), .en(en), .pa(pt2), .pb(pt3), .pc(pt1), .angle(ang_b));
  tca_lane u_lane_c (.clk(clk), .en(en), .pa(pt3), .pb(pt1), .pc(pt2), .angle(ang_c));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < LANE_LAT; s++) vld_pipe[s] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_pipe[0] <= in_valid;
      for (int s = 1; s < LANE_LAT; s++) vld_pipe[s] <= vld_pipe[s-1];
      out_valid <= vld_pipe[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_pipe[0] <= deg_in;
      for (int s = 1; s < LANE_LAT; s++) deg_pipe[s] <= deg_pipe[s-1];
      degenerate  <= deg_pipe[LANE_LAT-1];
      angle_opp_a <= deg_pipe[LANE_LAT-1] ? '0 : ang_a;
      angle_opp_b <= deg_pipe[LANE_LAT-1] ? '0 : ang_b;
      angle_opp_c <= deg_pipe[LANE_LAT-1] ? '0 : ang_c;
    end
  end

  `TCA_ASSERT(a_deg_zero, (out_valid && degenerate) |-> (angle_opp_a == '0 && angle_opp_b == '0 && angle_opp_c == '0), "degenerate result with nonzero angle")
  `TCA_ASSERT(a_range, out_valid |-> (angle_opp_a <= 16'd46080 && angle_opp_b <= 16'd46080 && angle_opp_c <= 16'd46080), "angle above 180 degrees")
  `TCA_ASSERT_NEXT(a_drain, (vld_pipe[LANE_LAT-1] && en), out_valid, "finished item lost at merge")
endmodule
